// ----- hw/rtl/mvfa_pkg.sv -----
// Shared constants, types and command format of the motion vector field accumulator.
`default_nettype none
package mvfa_pkg;

    // Map geometry: one entry per pixel, row-major, power-of-two row pitch
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    // Effective frame size must hold MAX_* and the 9-bit register value
    localparam int EW         = (XW + 1 > 9) ? XW + 1 : 9;
    // Stored coordinate width: low bits of a position or motion component
    localparam int CW         = 10;
    localparam int DW         = 2 * CW;
    // Command queue between front and back
    localparam int CMD_DEPTH  = 2;
    localparam int CMD_PW     = $clog2(CMD_DEPTH);

    // Input action codes
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_RECORD = 2'd1;
    localparam logic [1:0] ACT_FRAME  = 2'd2;
    localparam logic [1:0] ACT_READ   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOT_PAST = 2'd1;
    localparam logic [1:0] ST_OUTSIDE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ACCUMULATE = 2'd0;
    localparam logic [1:0] REG_WIDTH      = 2'd1;
    localparam logic [1:0] REG_HEIGHT     = 2'd2;

    // Work the back end carries out
    typedef enum logic [2:0] {
        OP_FILL,
        OP_PAINT,
        OP_COPY,
        OP_READ,
        OP_REPORT
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [1:0]            status;
        logic [CW-1:0]         vx;
        logic [CW-1:0]         vy;
        logic signed [16:0]    bpx;    // dest_x - half width
        logic signed [16:0]    bpy;
        logic signed [16:0]    bqx;    // source_x - half width
        logic signed [16:0]    bqy;
        logic [7:0]            span_x;
        logic [7:0]            span_y;
        logic [7:0]            rx;     // read pixel
        logic [7:0]            ry;
    } cmd_t;

    typedef struct packed {
        logic          accumulate;
        logic [EW-1:0] eff_w;
        logic [EW-1:0] eff_h;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mvfa_front.sv -----
// Front end: decodes each request into a back-end command.
`default_nettype none
module mvfa_front (
    input  wire mvfa_pkg::cfg_t  cfg,
    input  wire logic [1:0]      action,
    input  wire logic [7:0]      block_w,
    input  wire logic [7:0]      block_h,
    input  wire logic [15:0]     source_x,
    input  wire logic [15:0]     source_y,
    input  wire logic [15:0]     dest_x,
    input  wire logic [15:0]     dest_y,
    input  wire logic            from_past,
    input  wire logic [7:0]      pixel_x,
    input  wire logic [7:0]      pixel_y,
    output mvfa_pkg::cmd_t       cmd
);

    logic [6:0]         half_w;
    logic [6:0]         half_h;
    logic signed [16:0] vx_full;
    logic signed [16:0] vy_full;
    logic               zero_motion;
    logic               empty_block;
    logic               outside;

    // Record geometry
    assign half_w  = block_w[7:1];
    assign half_h  = block_h[7:1];
    assign vx_full = $signed({dest_x[15], dest_x}) - $signed({source_x[15], source_x});
    assign vy_full = $signed({dest_y[15], dest_y}) - $signed({source_y[15], source_y});
    assign zero_motion = (vx_full == 17'sd0) && (vy_full == 17'sd0);
    assign empty_block = (half_w == 7'd0) || (half_h == 7'd0);

    // Read window check
    assign outside = ({{(mvfa_pkg::EW-8){1'b0}}, pixel_x} >= cfg.eff_w) ||
                     ({{(mvfa_pkg::EW-8){1'b0}}, pixel_y} >= cfg.eff_h);

    always_comb
    begin
        cmd.vx     = vx_full[mvfa_pkg::CW-1:0];
        cmd.vy     = vy_full[mvfa_pkg::CW-1:0];
        cmd.bpx    = $signed({dest_x[15], dest_x}) - $signed({10'd0, half_w});
        cmd.bpy    = $signed({dest_y[15], dest_y}) - $signed({10'd0, half_h});
        cmd.bqx    = $signed({source_x[15], source_x}) - $signed({10'd0, half_w});
        cmd.bqy    = $signed({source_y[15], source_y}) - $signed({10'd0, half_h});
        cmd.span_x = {half_w, 1'b0};
        cmd.span_y = {half_h, 1'b0};
        cmd.rx     = pixel_x;
        cmd.ry     = pixel_y;
        cmd.op     = mvfa_pkg::OP_REPORT;
        cmd.status = mvfa_pkg::ST_DONE;
        unique case (action)
            mvfa_pkg::ACT_START:  cmd.op = mvfa_pkg::OP_FILL;
            mvfa_pkg::ACT_RECORD:
            begin
                if (!from_past)
                    cmd.status = mvfa_pkg::ST_NOT_PAST;
                else if (!zero_motion && !empty_block)
                    cmd.op = mvfa_pkg::OP_PAINT;
            end
            mvfa_pkg::ACT_FRAME:  cmd.op = mvfa_pkg::OP_COPY;
            mvfa_pkg::ACT_READ:
            begin
                if (outside)
                    cmd.status = mvfa_pkg::ST_OUTSIDE;
                else
                    cmd.op = mvfa_pkg::OP_READ;
            end
            default: cmd.op = mvfa_pkg::OP_REPORT;
        endcase
    end

endmodule
`default_nettype wire

// ----- hw/rtl/mvfa_cmd_queue.sv -----
// Short command queue between the front and back ends.
`default_nettype none
module mvfa_cmd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire mvfa_pkg::cmd_t wr_cmd,
    output logic                full,
    input  wire logic           rd,
    output mvfa_pkg::cmd_t      rd_cmd,
    output logic                valid
);

    mvfa_pkg::cmd_t             slot_reg [mvfa_pkg::CMD_DEPTH];
    logic [mvfa_pkg::CMD_PW-1:0] wp_reg, wp_next;
    logic [mvfa_pkg::CMD_PW-1:0] rp_reg, rp_next;
    logic [mvfa_pkg::CMD_PW:0]   cnt_reg, cnt_next;
    logic                        do_wr, do_rd;

    assign full   = (cnt_reg == (mvfa_pkg::CMD_PW+1)'(mvfa_pkg::CMD_DEPTH));
    assign valid  = (cnt_reg != '0);
    assign rd_cmd = slot_reg[rp_reg];
    assign do_wr  = wr && !full;
    assign do_rd  = rd && valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_wr)
            wp_next = (wp_reg == mvfa_pkg::CMD_PW'(mvfa_pkg::CMD_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (do_rd)
            rp_next = (rp_reg == mvfa_pkg::CMD_PW'(mvfa_pkg::CMD_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 1'b1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr_cmd;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/mvfa_back.sv -----
// Back end: map memories, fill/copy/paint/read sequencer and result register.
`default_nettype none
module mvfa_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mvfa_pkg::cfg_t cfg,
    input  wire logic           cmd_valid,
    input  wire mvfa_pkg::cmd_t cmd_in,
    output logic                cmd_pop,
    output logic                empty,
    input  wire logic           pop,
    output logic [8:0]          motion_x,
    output logic [8:0]          motion_y,
    output logic [9:0]          origin_x,
    output logic [9:0]          origin_y,
    output logic [1:0]          status
);

    localparam int AW = mvfa_pkg::AW;
    localparam int XW = mvfa_pkg::XW;
    localparam int YW = mvfa_pkg::YW;
    localparam int CW = mvfa_pkg::CW;
    localparam int DW = mvfa_pkg::DW;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FILL  = 6'b000010,
        S_COPY  = 6'b000100,
        S_PAINT = 6'b001000,
        S_READ  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        PW_CUR_PREV,
        PW_CUR_DIRECT,
        PW_PREV_CUR
    } pw_kind_t;

    state_t          state_reg, state_next;
    mvfa_pkg::cmd_t  cmd_reg, cmd_next;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [7:0]      i_reg, i_next;
    logic [7:0]      j_reg, j_next;

    logic            pw_valid_reg, pw_valid_next;
    logic [AW-1:0]   pw_addr_reg, pw_addr_next;
    pw_kind_t        pw_kind_reg, pw_kind_next;

    logic            res_valid_reg, res_valid_next;
    logic [8:0]      mx_reg, mx_next;
    logic [8:0]      my_reg, my_next;
    logic [9:0]      gx_reg, gx_next;
    logic [9:0]      gy_reg, gy_next;
    logic [1:0]      st_reg, st_next;

    // Map memories
    logic [DW-1:0]   cur_mem  [1 << AW];
    logic [DW-1:0]   prev_mem [1 << AW];
    logic [DW-1:0]   cur_rd_reg, prev_rd_reg;
    logic            cur_we, prev_we, cur_re, prev_re;
    logic [AW-1:0]   cur_wa, prev_wa, cur_ra, prev_ra;
    logic [DW-1:0]   cur_wd, prev_wd, fill_wd;

    // Paint geometry
    logic signed [17:0] px, py, qx, qy;
    logic signed [17:0] lim_w, lim_h;
    logic               in_range;
    logic [AW-1:0]      dst_addr, src_addr;
    logic               last_iter;
    logic [CW-1:0]      rd_sx, rd_sy, pix_x, pix_y;

    assign px    = 18'(cmd_reg.bpx) + $signed({10'd0, i_reg});
    assign py    = 18'(cmd_reg.bpy) + $signed({10'd0, j_reg});
    assign qx    = 18'(cmd_reg.bqx) + $signed({10'd0, i_reg});
    assign qy    = 18'(cmd_reg.bqy) + $signed({10'd0, j_reg});
    assign lim_w = $signed({{(18-mvfa_pkg::EW){1'b0}}, cfg.eff_w});
    assign lim_h = $signed({{(18-mvfa_pkg::EW){1'b0}}, cfg.eff_h});
    assign in_range = !px[17] && (px < lim_w) && !py[17] && (py < lim_h) &&
                      !qx[17] && (qx < lim_w) && !qy[17] && (qy < lim_h);
    assign dst_addr  = {py[YW-1:0], px[XW-1:0]};
    assign src_addr  = {qy[YW-1:0], qx[XW-1:0]};
    assign last_iter = (i_reg == cmd_reg.span_x - 8'd1) && (j_reg == cmd_reg.span_y - 8'd1);

    // Start fill value: identity position or zero motion
    assign fill_wd = cfg.accumulate ?
                     {CW'(cnt_reg[XW-1:0]), CW'(cnt_reg[AW-1:XW])} : '0;

    // Memory port steering
    always_comb
    begin
        cur_we  = 1'b0;
        prev_we = 1'b0;
        cur_wa  = pw_addr_reg;
        prev_wa = pw_addr_reg;
        cur_wd  = prev_rd_reg;
        prev_wd = cur_rd_reg;
        if (state_reg == S_FILL)
        begin
            cur_we  = 1'b1;
            prev_we = 1'b1;
            cur_wa  = cnt_reg;
            prev_wa = cnt_reg;
            cur_wd  = fill_wd;
            prev_wd = fill_wd;
        end
        else if (pw_valid_reg)
        begin
            case (pw_kind_reg)
                PW_CUR_PREV:   cur_we = 1'b1;
                PW_CUR_DIRECT:
                begin
                    cur_we = 1'b1;
                    cur_wd = {cmd_reg.vx, cmd_reg.vy};
                end
                PW_PREV_CUR:   prev_we = 1'b1;
                default:       cur_we = 1'b0;
            endcase
        end
        cur_re  = (state_reg == S_COPY) || (state_reg == S_READ);
        cur_ra  = (state_reg == S_READ) ? {YW'(cmd_reg.ry), XW'(cmd_reg.rx)} : cnt_reg;
        prev_re = (state_reg == S_PAINT) && in_range && cfg.accumulate;
        prev_ra = src_addr;
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
            cur_mem[cur_wa] <= cur_wd;
        if (cur_re)
            cur_rd_reg <= cur_mem[cur_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (prev_re)
            prev_rd_reg <= prev_mem[prev_ra];
    end

    // Read result arithmetic
    assign rd_sx = cur_rd_reg[DW-1:CW];
    assign rd_sy = cur_rd_reg[CW-1:0];
    assign pix_x = CW'(cmd_reg.rx);
    assign pix_y = CW'(cmd_reg.ry);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pw_valid_next  = 1'b0;
        pw_addr_next   = pw_addr_reg;
        pw_kind_next   = pw_kind_reg;
        res_valid_next = res_valid_reg && !pop;
        mx_next        = mx_reg;
        my_next        = my_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        st_next        = st_reg;
        cmd_pop        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    cnt_next = '0;
                    i_next   = 8'd0;
                    j_next   = 8'd0;
                    case (cmd_in.op)
                        mvfa_pkg::OP_FILL:  state_next = S_FILL;
                        mvfa_pkg::OP_PAINT: state_next = S_PAINT;
                        mvfa_pkg::OP_COPY:  state_next = S_COPY;
                        mvfa_pkg::OP_READ:  state_next = S_READ;
                        default:            state_next = S_DONE;
                    endcase
                end
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = S_DONE;
            end
            S_COPY:
            begin
                pw_valid_next = 1'b1;
                pw_addr_next  = cnt_reg;
                pw_kind_next  = PW_PREV_CUR;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                    state_next = S_DONE;
            end
            S_PAINT:
            begin
                pw_valid_next = in_range;
                pw_addr_next  = dst_addr;
                pw_kind_next  = cfg.accumulate ? PW_CUR_PREV : PW_CUR_DIRECT;
                if (j_reg == cmd_reg.span_y - 8'd1)
                begin
                    j_next = 8'd0;
                    i_next = i_reg + 8'd1;
                end
                else
                    j_next = j_reg + 8'd1;
                if (last_iter)
                    state_next = S_DONE;
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                res_valid_next = 1'b1;
                st_next        = cmd_reg.status;
                mx_next        = '0;
                my_next        = '0;
                gx_next        = '0;
                gy_next        = '0;
                if (cmd_reg.op == mvfa_pkg::OP_READ)
                begin
                    if (cfg.accumulate)
                    begin
                        gx_next = rd_sx;
                        gy_next = rd_sy;
                        mx_next = 9'(pix_x - rd_sx);
                        my_next = 9'(pix_y - rd_sy);
                    end
                    else
                    begin
                        mx_next = rd_sx[8:0];
                        my_next = rd_sy[8:0];
                        gx_next = pix_x - rd_sx;
                        gy_next = pix_y - rd_sy;
                    end
                end
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pw_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pw_valid_reg  <= pw_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cnt_reg     <= cnt_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        pw_addr_reg <= pw_addr_next;
        pw_kind_reg <= pw_kind_next;
        mx_reg      <= mx_next;
        my_reg      <= my_next;
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        st_reg      <= st_next;
    end

    assign empty    = !res_valid_reg;
    assign motion_x = mx_reg;
    assign motion_y = my_reg;
    assign origin_x = gx_reg;
    assign origin_y = gy_reg;
    assign status   = st_reg;

`ifndef SYNTH
    // A delayed write only follows a paint or copy step
    a_pw_source: assert property (@(posedge clk) disable iff (!rst_n)
        pw_valid_reg |-> ($past(state_reg) == S_PAINT || $past(state_reg) == S_COPY))
        else $error("delayed map write without a paint or copy step");
    // A command completes only when the result slot is free
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !res_valid_reg)
        else $error("result overwritten before it was taken");
    // Fill never collides with a delayed write
    a_fill_port: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !pw_valid_reg)
        else $error("fill collides with a delayed write");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/motion_vector_field_accumulator.sv -----
// Top level: configuration registers, front end, command queue and back end.
//
// Requests enter through push/full and are taken when push is high and full
// is low. Each request yields exactly one result, shown while empty is low
// and taken when pop is high. The user must write configuration through
// cfg_write, cfg_index and cfg_data while the block is idle; the block itself
// does not enforce this. A short command queue decouples intake from
// execution, so new requests are taken while a result waits. Fill, copy and
// paint steps go one pixel per cycle through the single write port of each
// map memory.
// Maps hold no defined content after reset until a start request; there is
// no clearing pass. Reset empties the queue and the result slot and restores
// register defaults. While pop is held low the result stays and the back end
// waits; intake goes on until the queue is full.
`default_nettype none
module motion_vector_field_accumulator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  block_w,
    input  wire logic [7:0]  block_h,
    input  wire logic [15:0] source_x,
    input  wire logic [15:0] source_y,
    input  wire logic [15:0] dest_x,
    input  wire logic [15:0] dest_y,
    input  wire logic        from_past,
    input  wire logic [7:0]  pixel_x,
    input  wire logic [7:0]  pixel_y,
    output logic             empty,
    input  wire logic        pop,
    output logic [8:0]       motion_x,
    output logic [8:0]       motion_y,
    output logic [9:0]       origin_x,
    output logic [9:0]       origin_y,
    output logic [1:0]       status,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    logic           accumulate_reg;
    logic [8:0]     width_reg;
    logic [8:0]     height_reg;
    mvfa_pkg::cfg_t cfg;
    mvfa_pkg::cmd_t front_cmd, queue_cmd;
    logic           queue_valid, queue_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accumulate_reg <= 1'b0;
            width_reg      <= 9'd256;
            height_reg     <= 9'd256;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mvfa_pkg::REG_ACCUMULATE: accumulate_reg <= cfg_data[0];
                mvfa_pkg::REG_WIDTH:      width_reg      <= cfg_data;
                mvfa_pkg::REG_HEIGHT:     height_reg     <= cfg_data;
                default:                  accumulate_reg <= accumulate_reg;
            endcase
        end
    end

    // Frame size saturated to the map size
    always_comb
    begin
        cfg.accumulate = accumulate_reg;
        cfg.eff_w = (mvfa_pkg::EW'(width_reg) > mvfa_pkg::EW'(mvfa_pkg::MAX_WIDTH)) ?
                    mvfa_pkg::EW'(mvfa_pkg::MAX_WIDTH) : mvfa_pkg::EW'(width_reg);
        cfg.eff_h = (mvfa_pkg::EW'(height_reg) > mvfa_pkg::EW'(mvfa_pkg::MAX_HEIGHT)) ?
                    mvfa_pkg::EW'(mvfa_pkg::MAX_HEIGHT) : mvfa_pkg::EW'(height_reg);
    end

    mvfa_front u_front (
        .cfg       (cfg),
        .action    (action),
        .block_w   (block_w),
        .block_h   (block_h),
        .source_x  (source_x),
        .source_y  (source_y),
        .dest_x    (dest_x),
        .dest_y    (dest_y),
        .from_past (from_past),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .cmd       (front_cmd)
    );

    mvfa_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (push),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd     (queue_pop),
        .rd_cmd (queue_cmd),
        .valid  (queue_valid)
    );

    mvfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (queue_valid),
        .cmd_in    (queue_cmd),
        .cmd_pop   (queue_pop),
        .empty     (empty),
        .pop       (pop),
        .motion_x  (motion_x),
        .motion_y  (motion_y),
        .origin_x  (origin_x),
        .origin_y  (origin_y),
        .status    (status)
    );

endmodule
`default_nettype wire
